/* sv/pit_pkg.sv */
// Package for the point-in-triangle test unit.
// Holds the edge count and the per-edge sign type; no dependencies.
package pit_pkg;

  // Edge count of a triangle; each edge is tested against the point.
  localparam int unsigned NUM_EDGES = 3;

  // Outcome of one edge cross product compared against zero.
  typedef struct packed {
    logic pos;
    logic neg;
  } edge_sign_t;

endpackage : pit_pkg

/* sv/pit_in_if.sv */
// Input channel interface of the point-in-triangle test unit.
// Carries valid, ready and the triangle corners plus the test point; no dependencies.
interface pit_in_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] corner_a_x;
  logic signed [COORD_BITS-1:0] corner_a_y;
  logic signed [COORD_BITS-1:0] corner_b_x;
  logic signed [COORD_BITS-1:0] corner_b_y;
  logic signed [COORD_BITS-1:0] corner_c_x;
  logic signed [COORD_BITS-1:0] corner_c_y;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;

  modport source (
    output valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
           corner_c_x, corner_c_y, point_x, point_y,
    input  ready
  );

  modport sink (
    input  valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
           corner_c_x, corner_c_y, point_x, point_y,
    output ready
  );
endinterface : pit_in_if

/* sv/pit_out_if.sv */
// Result channel interface of the point-in-triangle test unit.
// Carries valid, ready and the two result flags; no dependencies.
interface pit_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic on_edge_case;

  modport source (
    output valid, inside_res, on_edge_case,
    input  ready
  );

  modport sink (
    input  valid, inside_res, on_edge_case,
    output ready
  );
endinterface : pit_out_if

/* sv/point_in_triangle_test_unit.sv */
// Point-in-triangle edge-function test, three register stages.
// Depends on pit_pkg, pit_in_if and pit_out_if.
//
//   Channel  Direction  Carries
//   in_i     sink       corners A, B, C and point T, COORD_BITS each, signed
//   out_o    source     inside_res, on_edge_case
//
// One transaction enters per cycle while in_i.ready is high; its result passes through
// the stages in turn: edge differences, the edge multipliers, and the sign compare
// that forms the flags in the output register.
// Reset clears only the stage valid bits. A stall on out_o holds each stage that
// is full; empty stages still fill, so bubbles close up and nothing is dropped.
module point_in_triangle_test_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pit_in_if.sink           in_i,
  pit_out_if.source        out_o
);
  import pit_pkg::*;

  localparam int unsigned DiffBits = COORD_BITS + 1;
  localparam int unsigned ProdBits = 2 * DiffBits;

  // Corners ordered so that edge e runs from corner e to corner e+1.
  logic signed [COORD_BITS-1:0] vx_w [NUM_EDGES];
  logic signed [COORD_BITS-1:0] vy_w [NUM_EDGES];

  // Stage 1 registers: differences and the bounding check.
  logic                       v1_q;
  logic signed [DiffBits-1:0] ux_d [NUM_EDGES];
  logic signed [DiffBits-1:0] uy_d [NUM_EDGES];
  logic signed [DiffBits-1:0] tx_d [NUM_EDGES];
  logic signed [DiffBits-1:0] ty_d [NUM_EDGES];
  logic signed [DiffBits-1:0] ux_q [NUM_EDGES];
  logic signed [DiffBits-1:0] uy_q [NUM_EDGES];
  logic signed [DiffBits-1:0] tx_q [NUM_EDGES];
  logic signed [DiffBits-1:0] ty_q [NUM_EDGES];
  logic                       beyond1_d;
  logic                       beyond1_q;

  // Stage 2 registers: the two products of each edge.
  logic                       v2_q;
  logic signed [ProdBits-1:0] lhs_d [NUM_EDGES];
  logic signed [ProdBits-1:0] rhs_d [NUM_EDGES];
  logic signed [ProdBits-1:0] lhs_q [NUM_EDGES];
  logic signed [ProdBits-1:0] rhs_q [NUM_EDGES];
  logic                       beyond2_q;

  // Stage 3 registers: the result flags.
  logic       v3_q;
  edge_sign_t sign_w [NUM_EDGES];
  logic       inside_d;
  logic       zero_d;
  logic       inside_q;
  logic       zero_q;

  // Per-stage handshake: a stage loads when it is empty or its successor loads.
  logic en1_w;
  logic en2_w;
  logic en3_w;

  assign en3_w = !v3_q || out_o.ready;
  assign en2_w = !v2_q || en3_w;
  assign en1_w = !v1_q || en2_w;
  assign in_i.ready = en1_w;

  assign vx_w[0] = in_i.corner_a_x;
  assign vy_w[0] = in_i.corner_a_y;
  assign vx_w[1] = in_i.corner_b_x;
  assign vy_w[1] = in_i.corner_b_y;
  assign vx_w[2] = in_i.corner_c_x;
  assign vy_w[2] = in_i.corner_c_y;

  // Stage 1: edge vectors and point offsets, each one bit wider than a coordinate.
  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      ux_d[e] = $signed({vx_w[(e+1)%NUM_EDGES][COORD_BITS-1], vx_w[(e+1)%NUM_EDGES]})
              - $signed({vx_w[e][COORD_BITS-1], vx_w[e]});
      uy_d[e] = $signed({vy_w[(e+1)%NUM_EDGES][COORD_BITS-1], vy_w[(e+1)%NUM_EDGES]})
              - $signed({vy_w[e][COORD_BITS-1], vy_w[e]});
      tx_d[e] = $signed({in_i.point_x[COORD_BITS-1], in_i.point_x})
              - $signed({vx_w[e][COORD_BITS-1], vx_w[e]});
      ty_d[e] = $signed({in_i.point_y[COORD_BITS-1], in_i.point_y})
              - $signed({vy_w[e][COORD_BITS-1], vy_w[e]});
    end
  end

  // Stage 1: the point lies strictly beyond all three corners on one side.
  always_comb begin
    beyond1_d =
      (in_i.point_x < vx_w[0] && in_i.point_x < vx_w[1] && in_i.point_x < vx_w[2]) ||
      (in_i.point_x > vx_w[0] && in_i.point_x > vx_w[1] && in_i.point_x > vx_w[2]) ||
      (in_i.point_y < vy_w[0] && in_i.point_y < vy_w[1] && in_i.point_y < vy_w[2]) ||
      (in_i.point_y > vy_w[0] && in_i.point_y > vy_w[1] && in_i.point_y > vy_w[2]);
  end

  // Stage 2: cross product halves, exact at twice the difference width.
  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      lhs_d[e] = ProdBits'(ux_q[e]) * ProdBits'(ty_q[e]);
      rhs_d[e] = ProdBits'(uy_q[e]) * ProdBits'(tx_q[e]);
    end
  end

  // Stage 3: edge signs, then the inside decision.
  always_comb begin
    logic all_pos;
    logic all_neg;
    all_pos = 1'b1;
    all_neg = 1'b1;
    zero_d  = 1'b0;
    for (int e = 0; e < NUM_EDGES; e++) begin
      sign_w[e].pos = lhs_q[e] > rhs_q[e];
      sign_w[e].neg = lhs_q[e] < rhs_q[e];
      all_pos = all_pos & sign_w[e].pos;
      all_neg = all_neg & sign_w[e].neg;
      zero_d  = zero_d | !(sign_w[e].pos | sign_w[e].neg);
    end
    if (zero_d) begin
      inside_d = !beyond2_q;
    end else begin
      inside_d = all_pos | all_neg;
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1_w) v1_q <= in_i.valid;
      if (en2_w) v2_q <= v1_q;
      if (en3_w) v3_q <= v2_q;
    end
  end

  // Stage payload registers, loaded with their stage.
  always_ff @(posedge clk_i) begin
    if (en1_w) begin
      ux_q      <= ux_d;
      uy_q      <= uy_d;
      tx_q      <= tx_d;
      ty_q      <= ty_d;
      beyond1_q <= beyond1_d;
    end
    if (en2_w) begin
      lhs_q     <= lhs_d;
      rhs_q     <= rhs_d;
      beyond2_q <= beyond1_q;
    end
    if (en3_w) begin
      inside_q <= inside_d;
      zero_q   <= zero_d;
    end
  end

  assign out_o.valid        = v3_q;
  assign out_o.inside_res   = inside_q;
  assign out_o.on_edge_case = zero_q;

endmodule : point_in_triangle_test_unit
